[design/skf_pkg.sv]
package skf_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = (FRAC_BITS > 16) ? FRAC_BITS : 16;

  localparam int VAL_W   = 32;               // estimate, variance, result
  localparam int CFG_W   = 24;               // noise registers
  localparam int IDX_W   = 1;
  localparam int GAIN_W  = GAIN_BITS + 1;    // gain spans 0 .. 1.0 inclusive
  localparam int DEN_W   = VAL_W + 1;        // predicted variance plus noise
  localparam int REM_W   = DEN_W + 1;        // shifted partial remainder
  localparam int PROD_W  = DEN_W + GAIN_W;   // shift-add product register
  localparam int CNT_W   = $clog2(GAIN_W);

  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE     = 1'd0;
  localparam logic [IDX_W-1:0] REG_MEASUREMENT_NOISE = 1'd1;

  localparam logic [CFG_W-1:0] PROCESS_NOISE_RST     = 24'd1442;
  localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RST = 24'd40436;

  localparam logic [VAL_W-1:0]  VAR_RST  = VAL_W'(1) << FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;
  localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(GAIN_W - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PRED  = 7'b0000010,
    S_DENOM = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_MINIT = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_WRITE = 7'b1000000
  } state_t;

endpackage

[design/scalar_kalman_filter.sv]
// channel | direction | ports                          | handshake
// --------+-----------+--------------------------------+----------------------
// in      | input     | in_measurement                 | in_valid / in_ready
// out     | output     | out_filtered_estimate          | out_valid / out_ready
// cfg     | input     | cfg_index, cfg_wdata           | cfg_we, no wait
//
// An item is taken only in S_IDLE, and the next not before this one is written:
// the accept state, setup states S_PRED and S_DENOM, a radix-2 restoring divider
// for the 17-bit gain, a multiplier load state, then two shift-add multipliers
// run side by side over the gain bits, one bit a cycle, and a final update state.
// The result sits in an output register; a new item is taken while it waits.
// The update cycle holds while the previous result has not been taken.
// Synchronous active-low reset restores the noise registers, estimate 0 and
// variance 1.0.
module scalar_kalman_filter (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                in_measurement,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [skf_pkg::VAL_W-1:0]  out_filtered_estimate,
  input  logic                       cfg_we,
  input  logic [skf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [skf_pkg::CFG_W-1:0]  cfg_wdata
);
  import skf_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]  pnoise_r, mnoise_r;
  logic [VAL_W-1:0]  est_r, est_nxt;
  logic [VAL_W-1:0]  var_r;
  logic [VAL_W-1:0]  out_data_r;
  logic              out_valid_r;

  logic [SAMPLE_BITS-1:0] z_r;
  logic [VAL_W-1:0]  ppred_r;
  logic [VAL_W-1:0]  absd_r;
  logic              up_r;
  logic [DEN_W-1:0]  denom_r;
  logic              den_zero_r;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [GAIN_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] prod_a_r, prod_b_r, prod_a_nxt, prod_b_nxt;

  logic [VAL_W+FRAC_BITS-1:0] zf;
  logic [DEN_W-1:0]  psum;
  logic [VAL_W-1:0]  psat;
  logic [REM_W-1:0]  shifted, diff;
  logic              qbit;
  logic [GAIN_W-1:0] gain;
  logic [DEN_W:0]    sum_a, sum_b;
  logic [VAL_W-1:0]  step, var_new;
  logic              out_free;

  assign in_ready              = (state_r == S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_filtered_estimate = out_data_r;
  assign out_free              = !out_valid_r || out_ready;

  // sample scaled to fixed point
  assign zf   = {{(VAL_W-SAMPLE_BITS){1'b0}}, z_r, {FRAC_BITS{1'b0}}};
  assign psum = {1'b0, var_r} + {{(DEN_W-CFG_W){1'b0}}, pnoise_r};
  assign psat = psum[VAL_W] ? {VAL_W{1'b1}} : psum[VAL_W-1:0];

  // first divide step compares without shifting (quotient bit GAIN_BITS)
  assign shifted = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign diff    = shifted - {1'b0, denom_r};
  assign qbit    = !diff[REM_W-1];
  assign rem_nxt = qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];

  assign gain = den_zero_r ? '0 : q_r;

  // shift-add multiply, multiplier bits enter at the bottom, LSB first
  assign sum_a = {1'b0, prod_a_r[PROD_W-1:GAIN_W]}
               + (prod_a_r[0] ? {{(DEN_W+1-VAL_W){1'b0}}, absd_r} : '0);
  assign sum_b = {1'b0, prod_b_r[PROD_W-1:GAIN_W]}
               + (prod_b_r[0] ? {{(DEN_W+1-VAL_W){1'b0}}, ppred_r} : '0);
  assign prod_a_nxt = {sum_a, prod_a_r[GAIN_W-1:1]};
  assign prod_b_nxt = {sum_b, prod_b_r[GAIN_W-1:1]};

  assign step    = prod_a_r[GAIN_BITS +: VAL_W];
  assign var_new = prod_b_r[GAIN_BITS +: VAL_W];
  assign est_nxt = up_r ? (est_r + step) : (est_r - step);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_PRED;
      S_PRED:  state_nxt = S_DENOM;
      S_DENOM: state_nxt = S_DIV;
      S_DIV:   if (cnt_r == LAST_STEP) state_nxt = S_MINIT;
      S_MINIT: state_nxt = S_MUL;
      S_MUL:   if (cnt_r == LAST_STEP) state_nxt = S_WRITE;
      S_WRITE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pnoise_r    <= PROCESS_NOISE_RST;
      mnoise_r    <= MEASUREMENT_NOISE_RST;
      est_r       <= '0;
      var_r       <= VAR_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PROCESS_NOISE:     pnoise_r <= cfg_wdata;
          REG_MEASUREMENT_NOISE: mnoise_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_WRITE && out_free) begin
        est_r       <= est_nxt;
        var_r       <= var_new;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) z_r <= in_measurement[SAMPLE_BITS-1:0];
      end
      S_PRED: begin
        ppred_r <= psat;
        up_r    <= (zf[VAL_W-1:0] >= est_r);
        absd_r  <= (zf[VAL_W-1:0] >= est_r) ? (zf[VAL_W-1:0] - est_r)
                                            : (est_r - zf[VAL_W-1:0]);
      end
      S_DENOM: begin
        denom_r    <= {1'b0, ppred_r} + {{(DEN_W-CFG_W){1'b0}}, mnoise_r};
        den_zero_r <= (ppred_r == '0) && (mnoise_r == '0);
        rem_r      <= {1'b0, ppred_r};
        cnt_r      <= '0;
      end
      S_DIV: begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[GAIN_W-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
      end
      S_MINIT: begin
        prod_a_r <= {{DEN_W{1'b0}}, gain};
        prod_b_r <= {{DEN_W{1'b0}}, GAIN_ONE - gain};
        cnt_r    <= '0;
      end
      S_MUL: begin
        prod_a_r <= prod_a_nxt;
        prod_b_r <= prod_b_nxt;
        cnt_r    <= cnt_r + 1'b1;
      end
      S_WRITE: begin
        if (out_free) out_data_r <= est_nxt;
      end
      default: ;
    endcase
  end

endmodule
